/* hdl/scale_rotate_blit_address_gen_defines.svh */
// assertion macros for the blit address generator
`ifndef SCALE_ROTATE_BLIT_ADDRESS_GEN_DEFINES_SVH
`define SCALE_ROTATE_BLIT_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SRB_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/srb_pkg.sv */
// types, constants and helpers shared by the blit address generator
`timescale 1ns / 1ps
package srb_pkg;

    localparam int CRD_W  = 11;
    localparam int DIM_W  = 12;
    localparam int OFS_W  = 24;
    localparam int WS_W   = 22;
    localparam int BPP_W  = 2;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 22;
    localparam int NUM_W  = CRD_W + DIM_W;
    localparam int MAX_DIM_DEF = 2048;

    typedef enum logic [1:0] {
        TURN_0   = 2'd0,
        TURN_90  = 2'd1,
        TURN_180 = 2'd2,
        TURN_270 = 2'd3
    } t_turn;

    typedef enum logic [IDX_W-1:0] {
        CFG_TURN         = 3'd0,
        CFG_PIXEL_BYTES  = 3'd1,
        CFG_SRC_COLS     = 3'd2,
        CFG_SRC_ROWS     = 3'd3,
        CFG_WIN_COLS     = 3'd4,
        CFG_WIN_ROWS     = 3'd5,
        CFG_PANEL_COLS   = 3'd6,
        CFG_WINDOW_START = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [CRD_W-1:0] src_col;
        logic [CRD_W-1:0] src_row;
        logic [OFS_W-1:0] src_byte_offset;
        logic [OFS_W-1:0] dst_byte_offset;
    } t_out_item;

    // zero counts as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v, input int lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > lim) begin
            r = DIM_W'(lim);
        end
        return r;
    endfunction

endpackage

/* hdl/scale_rotate_blit_address_gen.sv */
// top level: pipelined scale and rotate blit address generator
//
// channel   direction  signals                        handshake
// item in   input      i_start, i_item               taken when i_start and not o_busy
// result    output     o_strobe, o_result            one cycle, no back pressure
// config    input      i_cfg_we, i_cfg_idx, i_cfg_data  written when i_cfg_we
//
// one item per clock; the pipeline depth does not depend on MAX_DIM
// (2 setup stages, 6 divider stages at 2 quotient bits each, 3 mirror and offset stages)
// the two divisions by window width and height set the depth
// o_busy is high only while reset is held; synchronous active-low reset clears valid bits
// the result strobe cannot be stalled, so the pipeline advances every cycle
`timescale 1ns / 1ps
`include "scale_rotate_blit_address_gen_defines.svh"
module scale_rotate_blit_address_gen #(
    parameter int MAX_DIM = srb_pkg::MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  srb_pkg::t_in_item        i_item,
    output logic                     o_strobe,
    output srb_pkg::t_out_item       o_result,
    input  logic                     i_cfg_we,
    input  logic [srb_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [srb_pkg::CFG_W-1:0] i_cfg_data
);
    import srb_pkg::*;

    localparam int NSTG = DIM_W / 2;
    localparam int DLY  = NSTG;
    localparam int LAT  = NSTG + 5;

    // configuration registers
    t_turn             r_turn;
    logic [BPP_W-1:0]  r_bpp;
    logic [DIM_W-1:0]  r_src_cols, r_src_rows, r_win_cols, r_win_rows, r_panel_cols;
    logic [WS_W-1:0]   r_ws;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn       <= TURN_0;
            r_bpp        <= BPP_W'(2);
            r_src_cols   <= DIM_W'(320);
            r_src_rows   <= DIM_W'(240);
            r_win_cols   <= DIM_W'(320);
            r_win_rows   <= DIM_W'(240);
            r_panel_cols <= DIM_W'(320);
            r_ws         <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TURN:         r_turn       <= t_turn'(i_cfg_data[1:0]);
                CFG_PIXEL_BYTES:  r_bpp        <= i_cfg_data[BPP_W-1:0];
                CFG_SRC_COLS:     r_src_cols   <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_ROWS:     r_src_rows   <= i_cfg_data[DIM_W-1:0];
                CFG_WIN_COLS:     r_win_cols   <= i_cfg_data[DIM_W-1:0];
                CFG_WIN_ROWS:     r_win_rows   <= i_cfg_data[DIM_W-1:0];
                CFG_PANEL_COLS:   r_panel_cols <= i_cfg_data[DIM_W-1:0];
                CFG_WINDOW_START: r_ws         <= i_cfg_data[WS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] sw, sh, ww, wh, pw;
    logic             swap, mir_x, mir_y;
    assign sw = dim_eff(r_src_cols, MAX_DIM);
    assign sh = dim_eff(r_src_rows, MAX_DIM);
    assign ww = dim_eff(r_win_cols, MAX_DIM);
    assign wh = dim_eff(r_win_rows, MAX_DIM);
    assign pw = dim_eff(r_panel_cols, MAX_DIM);
    assign swap  = (r_turn == TURN_90) || (r_turn == TURN_270);
    assign mir_x = (r_turn == TURN_90) || (r_turn == TURN_180);
    assign mir_y = (r_turn == TURN_180) || (r_turn == TURN_270);

    logic accept;
    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // stage 1: clamp to the window
    logic             r_v1;
    logic [CRD_W-1:0] r_x1, r_y1;
    logic [CRD_W-1:0] n_x1, n_y1;

    always_comb begin
        n_x1 = i_item.col;
        n_y1 = i_item.row;
        if ({1'b0, i_item.col} >= ww) n_x1 = CRD_W'(ww - DIM_W'(1));
        if ({1'b0, i_item.row} >= wh) n_y1 = CRD_W'(wh - DIM_W'(1));
    end

    // stage 2: numerators of both divisions and the panel row product
    logic [CRD_W-1:0] pa, pb;
    assign pa = swap ? r_y1 : r_x1;
    assign pb = swap ? r_x1 : r_y1;

    logic [NUM_W-1:0] r_yp2;
    logic [CRD_W-1:0] r_x2;

    // divider lanes: a gives source column, b gives source row
    logic             r_vd [0:NSTG];
    logic [NUM_W-1:0] r_ra [0:NSTG];
    logic [NUM_W-1:0] r_rb [0:NSTG];
    logic [DIM_W-1:0] r_qa [0:NSTG];
    logic [DIM_W-1:0] r_qb [0:NSTG];
    logic [DIM_W-1:0] da, db;
    assign da = swap ? wh : ww;
    assign db = swap ? ww : wh;

    logic [NUM_W-1:0] n_ra [1:NSTG];
    logic [NUM_W-1:0] n_rb [1:NSTG];
    logic [DIM_W-1:0] n_qa [1:NSTG];
    logic [DIM_W-1:0] n_qb [1:NSTG];

    genvar k;
    generate
        for (k = 1; k <= NSTG; k++) begin : g_div
            always_comb begin
                int bitn;
                n_ra[k] = r_ra[k-1];
                n_rb[k] = r_rb[k-1];
                n_qa[k] = r_qa[k-1];
                n_qb[k] = r_qb[k-1];
                for (int j = 0; j < 2; j++) begin
                    bitn = DIM_W - 1 - 2 * (k - 1) - j;
                    if ((n_ra[k] >> bitn) >= NUM_W'(da)) begin
                        n_ra[k] = n_ra[k] - (NUM_W'(da) << bitn);
                        n_qa[k][bitn] = 1'b1;
                    end
                    if ((n_rb[k] >> bitn) >= NUM_W'(db)) begin
                        n_rb[k] = n_rb[k] - (NUM_W'(db) << bitn);
                        n_qb[k][bitn] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_ra[k] <= n_ra[k];
                r_rb[k] <= n_rb[k];
                r_qa[k] <= n_qa[k];
                r_qb[k] <= n_qb[k];
            end
        end
    endgenerate

    // destination offset path, runs beside the divider
    logic [OFS_W-1:0] r_dsum3, r_dmul4;
    logic [OFS_W-1:0] r_dst [0:DLY-1];

    // stages after the divider: mirror, linear index, byte scale
    logic             r_v9, r_v10, r_vo;
    logic [DIM_W-1:0] r_sx9, r_sy9, r_sx10, r_sy10;
    logic [OFS_W-1:0] r_lin10;

    always_ff @(posedge i_clk) begin
        r_x1 <= n_x1;
        r_y1 <= n_y1;

        r_ra[0] <= NUM_W'(pa) * NUM_W'(sw);
        r_rb[0] <= NUM_W'(pb) * NUM_W'(sh);
        r_qa[0] <= '0;
        r_qb[0] <= '0;
        r_yp2   <= NUM_W'(r_y1) * NUM_W'(pw);
        r_x2    <= r_x1;

        r_dsum3 <= OFS_W'(r_ws) + OFS_W'(r_yp2) + OFS_W'(r_x2);
        r_dmul4 <= r_dsum3 * OFS_W'(r_bpp);
        r_dst[0] <= r_dmul4;
        for (int i = 1; i < DLY; i++) r_dst[i] <= r_dst[i-1];

        r_sx9  <= mir_x ? (sw - DIM_W'(1) - r_qa[NSTG]) : r_qa[NSTG];
        r_sy9  <= mir_y ? (sh - DIM_W'(1) - r_qb[NSTG]) : r_qb[NSTG];
        r_sx10 <= r_sx9;
        r_sy10 <= r_sy9;
        r_lin10 <= OFS_W'(r_sy9) * OFS_W'(sw) + OFS_W'(r_sx9);

        o_result.src_col         <= r_sx10[CRD_W-1:0];
        o_result.src_row         <= r_sy10[CRD_W-1:0];
        o_result.src_byte_offset <= r_lin10 * OFS_W'(r_bpp);
        o_result.dst_byte_offset <= r_dst[DLY-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_vo  <= 1'b0;
            for (int i = 0; i <= NSTG; i++) r_vd[i] <= 1'b0;
        end else begin
            r_v1    <= accept;
            r_vd[0] <= r_v1;
            for (int i = 1; i <= NSTG; i++) r_vd[i] <= r_vd[i-1];
            r_v9  <= r_vd[NSTG];
            r_v10 <= r_v9;
            r_vo  <= r_v10;
        end
    end

    assign o_strobe = r_vo;

    `SRB_ASSERT(a_latency, o_strobe, $past(accept, LAT), "result without an item at fixed latency")
    `SRB_ASSERT_NEXT(a_enter, accept, r_v1, "accepted item did not enter the pipeline")
    `SRB_ASSERT(a_qa_range, r_vd[NSTG], r_qa[NSTG] < sw, "column quotient beyond source width")
    `SRB_ASSERT(a_rem_range, r_vd[NSTG], (r_ra[NSTG] < NUM_W'(da)) && (r_rb[NSTG] < NUM_W'(db)),
        "divider remainder not below divisor")

endmodule

/* sim/scale_rotate_blit_address_gen_tb.sv */
// testbench for the scale and rotate blit address generator
`timescale 1ns / 1ps
module scale_rotate_blit_address_gen_tb;
    import srb_pkg::*;

    localparam int LATENCY = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAXD = MAX_DIM_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    t_in_item i_item = '0;
    logic o_strobe;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    scale_rotate_blit_address_gen uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [1:0]       m_turn = 2'd0;
    logic [BPP_W-1:0] m_bpp = 2'd2;
    logic [DIM_W-1:0] m_src_cols = 12'd320, m_src_rows = 12'd240;
    logic [DIM_W-1:0] m_win_cols = 12'd320, m_win_rows = 12'd240;
    logic [DIM_W-1:0] m_panel_cols = 12'd320;
    logic [WS_W-1:0]  m_win_start = '0;

    t_in_item  pending_items[$];
    t_out_item expected_addrs[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit calm = 1'b0;

    function automatic longint dim_clip(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAXD) return MAXD;
        return longint'(v);
    endfunction

    function automatic t_out_item predict_addr(t_in_item it);
        longint sw, sh, ww, wh, pw, x, y, sx, sy;
        t_out_item r;
        sw = dim_clip(m_src_cols);
        sh = dim_clip(m_src_rows);
        ww = dim_clip(m_win_cols);
        wh = dim_clip(m_win_rows);
        pw = dim_clip(m_panel_cols);
        x = longint'(it.col);
        y = longint'(it.row);
        if (x >= ww) x = ww - 1;
        if (y >= wh) y = wh - 1;
        case (t_turn'(m_turn))
            TURN_90: begin
                sx = sw - 1 - (y * sw) / wh;
                sy = (x * sh) / ww;
            end
            TURN_180: begin
                sx = sw - 1 - (x * sw) / ww;
                sy = sh - 1 - (y * sh) / wh;
            end
            TURN_270: begin
                sx = (y * sw) / wh;
                sy = sh - 1 - (x * sh) / ww;
            end
            default: begin
                sx = (x * sw) / ww;
                sy = (y * sh) / wh;
            end
        endcase
        r.src_col = sx[CRD_W-1:0];
        r.src_row = sy[CRD_W-1:0];
        r.src_byte_offset = OFS_W'((sy * sw + sx) * longint'(m_bpp));
        r.dst_byte_offset = OFS_W'((longint'(m_win_start) + y * pw + x) * longint'(m_bpp));
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && pending_items.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
            i_item <= pending_items[0];
            i_start <= 1'b1;
        end else begin
            i_start <= 1'b0;
            i_item <= t_in_item'($urandom);
        end
    end

    // acceptance and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                expected_addrs.push_back(predict_addr(pending_items.pop_front()));
            end
            if (o_strobe) begin
                if (expected_addrs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_result);
                end else begin
                    t_out_item e;
                    e = expected_addrs.pop_front();
                    if (e.src_col !== o_result.src_col || e.src_row !== o_result.src_row ||
                        e.src_byte_offset !== o_result.src_byte_offset ||
                        e.dst_byte_offset !== o_result.dst_byte_offset) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp col %0d row %0d src %0d dst %0d, ",
                                      "got col %0d row %0d src %0d dst %0d"},
                                e.src_col, e.src_row, e.src_byte_offset, e.dst_byte_offset,
                                o_result.src_col, o_result.src_row,
                                o_result.src_byte_offset, o_result.dst_byte_offset);
                    end
                end
            end
            if ((i_start && !o_busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("scale_rotate_blit_address_gen test failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TURN:         m_turn = val[1:0];
            CFG_PIXEL_BYTES:  m_bpp = val[1:0];
            CFG_SRC_COLS:     m_src_cols = val[DIM_W-1:0];
            CFG_SRC_ROWS:     m_src_rows = val[DIM_W-1:0];
            CFG_WIN_COLS:     m_win_cols = val[DIM_W-1:0];
            CFG_WIN_ROWS:     m_win_rows = val[DIM_W-1:0];
            CFG_PANEL_COLS:   m_panel_cols = val[DIM_W-1:0];
            default:          m_win_start = val[WS_W-1:0];
        endcase
    endtask

    task automatic drain_pipe();
        while (pending_items.size() > 0 || expected_addrs.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic int unsigned rand_dim();
        case ($urandom_range(5))
            0: return 0;
            1: return 4095;
            2: return 2048;
            3: return $urandom_range(4095);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    task automatic push_item(int c, int r);
        t_in_item it;
        it.col = c[CRD_W-1:0];
        it.row = r[CRD_W-1:0];
        pending_items.push_back(it);
    endtask

    initial begin
        int lim;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: reset settings, corners, out-of-window clamp
        push_item(0, 0);
        push_item(319, 239);
        push_item(320, 240);
        push_item(2047, 2047);
        push_item(1365, 682);
        push_item(682, 1365);
        drain_pipe();
        // every turn with extreme sizes, zero pixel bytes, overflow
        for (int t = 0; t < 4; t++) begin
            write_reg(CFG_TURN, t);
            write_reg(CFG_PIXEL_BYTES, t);
            write_reg(CFG_SRC_COLS, (t % 2) ? 4095 : 0);
            write_reg(CFG_SRC_ROWS, (t % 2) ? 0 : 2048);
            write_reg(CFG_WIN_COLS, (t < 2) ? 2048 : 1);
            write_reg(CFG_WIN_ROWS, (t < 2) ? 7 : 0);
            write_reg(CFG_PANEL_COLS, (t < 2) ? 4095 : 0);
            write_reg(CFG_WINDOW_START, (t < 2) ? 32'h3FFFFF : 0);
            push_item(0, 0);
            push_item(2047, 2047);
            push_item(1024, 3);
            push_item(3, 1024);
            drain_pipe();
        end
        // random phases
        for (int ph = 0; ph < 28; ph++) begin
            write_reg(CFG_TURN, $urandom_range(3));
            write_reg(CFG_PIXEL_BYTES, $urandom_range(3));
            write_reg(CFG_SRC_COLS, rand_dim());
            write_reg(CFG_SRC_ROWS, rand_dim());
            write_reg(CFG_WIN_COLS, rand_dim());
            write_reg(CFG_WIN_ROWS, rand_dim());
            write_reg(CFG_PANEL_COLS, rand_dim());
            write_reg(CFG_WINDOW_START, $urandom);
            calm = (ph == 5);
            lim = int'(dim_clip(m_win_cols) > dim_clip(m_win_rows) ?
                       dim_clip(m_win_cols) : dim_clip(m_win_rows));
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(9) < 7)
                    push_item($urandom_range(lim), $urandom_range(lim));
                else
                    push_item($urandom_range(2047), $urandom_range(2047));
            end
            drain_pipe();
        end
        if (mismatches == 0) begin
            $display("scale_rotate_blit_address_gen test passed");
        end else begin
            $display("scale_rotate_blit_address_gen test failed");
        end
        $finish;
    end
endmodule

/* scale_rotate_blit_address_gen.f */
+incdir+hdl
hdl/srb_pkg.sv
hdl/scale_rotate_blit_address_gen.sv
sim/scale_rotate_blit_address_gen_tb.sv
